FILE: src/plir_pkg.sv
// Package for the positional insert/remove list.
// Holds the command and status codes and the control bundle sent to the cells.
// No dependencies.
package plir_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Broadcast to every cell in the chain for one accepted request
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: src/plir_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on plir_pkg for the field widths.
interface plir_req_intf import plir_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface plir_rsp_intf import plir_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] removed_value;
   logic [1:0]               status;
   logic [COUNT_W-1:0]       entry_count;

   modport source (output valid, removed_value, status, entry_count, input ready);
   modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

FILE: src/positional_insert_remove_list.sv
// Positional insert/remove list: top level with control, count and the cell chain.
// Depends on plir_pkg, plir_channels and plir_cell.
//
// Usage:
//   req_if carries one command per request: cmd (insert or remove), position
//   and value. rsp_if returns exactly one response per request: the removed
//   value (zero unless a remove succeeded), a status code and the entry count
//   after the command.
//   Every cell of the chain shifts in the same cycle, so a command finishes in
//   the cycle it is accepted; its response is registered and shows on rsp_if
//   in the next cycle. Throughput is one request per cycle while responses are
//   taken, set by the single shift step of the chain plus the response register.
//   A failed command (bad position, empty, full) leaves the list unchanged.
//   Reset clears the count and the response valid; cell contents are left as
//   they are since only entries below the count are ever read.
//   When the receiver stalls with a response held, req_if.ready drops until
//   that response is taken, unless it is taken in the same cycle.
module positional_insert_remove_list import plir_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   plir_req_intf.sink   req_if,
   plir_rsp_intf.source rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_removed_ff, rsp_removed_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     accept;
   logic [CMP_W-1:0]         pos_ext, cnt_ext;
   status_type               status;
   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
   logic signed [DATA_W-1:0] tap_or;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign pos_ext      = CMP_W'(req_if.position);
   assign cnt_ext      = CMP_W'(count_ff);

   // Command check
   always_comb begin
      status = ST_OK;
      if (req_if.cmd == CMD_INSERT) begin
         if (pos_ext > cnt_ext) begin
            status = ST_BAD_POS;
         end else if (count_ff == CAP_CNT) begin
            status = ST_FULL;
         end
      end else begin
         if (count_ff == '0) begin
            status = ST_EMPTY;
         end else if (pos_ext >= cnt_ext) begin
            status = ST_BAD_POS;
         end
      end
   end

   // Broadcast control to the chain
   always_comb begin
      ctrl.insert = accept && (req_if.cmd == CMD_INSERT) && (status == ST_OK);
      ctrl.remove = accept && (req_if.cmd == CMD_REMOVE) && (status == ST_OK);
      ctrl.pos    = req_if.position;
      ctrl.value  = req_if.value;
   end

   // Cell chain
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (k == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[k+1];
      end
      plir_cell #(
         .INDEX (k),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[k]),
         .tap        (cell_tap[k])
      );
   end

   // One-hot select of the entry at the position
   always_comb begin
      tap_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         tap_or = tap_or | cell_tap[k];
      end
   end

   // Count and response register
   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.remove) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_removed_in = ctrl.remove ? tap_or : '0;
         rsp_status_in  = status;
         rsp_count_in   = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.removed_value = rsp_removed_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.entry_count   = rsp_count_ff;

endmodule

FILE: src/plir_cell.sv
// One storage cell of the list chain: holds the entry at a fixed index.
// Takes the left neighbor on insert, the right neighbor on remove. Uses plir_pkg.
module plir_cell import plir_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CMP_W = 7
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] tap
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic [CMP_W-1:0]         pos_ext;

   assign pos_ext = CMP_W'(ctrl.pos);

   // Shift decision: entries at or past the position move by one
   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (MY_IDX == pos_ext) begin
            data_in = ctrl.value;
         end else if (MY_IDX > pos_ext) begin
            data_in = left_data;
         end
      end else if (ctrl.remove && (MY_IDX >= pos_ext)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // Contribution to the removed-value select
   assign tap  = (MY_IDX == pos_ext) ? data_ff : '0;

endmodule
